@@ rtl/bsdh_pkg.sv @@
// shared constants, control word types and the microcode table of the dual hash
package bsdh_pkg;

  localparam logic [63:0] SEED_ONE    = 64'h243f6a8885a308d3;
  localparam logic [63:0] SEED_TWO    = 64'h13198a2e03707344;
  localparam logic [63:0] GOLDEN      = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;
  localparam logic [31:0] LANE_MUL    = 32'd1315423911;
  localparam logic [63:0] CHAIN_INIT  = 64'd1469598103934665603;
  localparam logic [63:0] CHAIN_PRIME = 64'd1099511628211;

  localparam int PC_W = 6;
  localparam logic [PC_W-1:0] BYTE_ADDR  = 6'd0;
  localparam logic [PC_W-1:0] CLOSE_ADDR = 6'd31;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LDPRE,   // x = t ^ (t >> 30), t = source + golden
    OP_ML0,     // acc = x.lo * k.lo
    OP_ML1,     // acc += x.lo * k.hi << 32
    OP_ML2,     // x = acc + x.hi * k.lo << 32
    OP_XS27,
    OP_XS31,    // finish a mix: write it to its lane, or to x (xored with chain for the chain)
    OP_STEP,    // commit chain, advance position
    OP_EMIT     // load result registers, return to seeds
  } op_t;

  typedef enum logic [1:0] {
    SRC_LANE1,
    SRC_LANE2,
    SRC_POS,
    SRC_FIN
  } src_t;

  typedef enum logic [1:0] {
    DST_LANE1,
    DST_LANE2,
    DST_CHAIN,
    DST_FIN
  } dst_t;

  typedef enum logic [1:0] {
    K_A,
    K_B,
    K_PRIME
  } ksel_t;

  typedef enum logic [1:0] {
    FL_NEXT,
    FL_BYTE_END,
    FL_DONE
  } flow_t;

  typedef struct packed {
    op_t   op;
    src_t  src;
    dst_t  dst;
    ksel_t ksel;
    flow_t flow;
  } ctrl_t;

  typedef struct packed {
    logic  exec;
    logic  load_byte;
    ctrl_t word;
  } dp_ctrl_t;

  function automatic ctrl_t cw(op_t op, src_t src, dst_t dst, ksel_t ksel, flow_t flow);
    ctrl_t w;
    w.op   = op;
    w.src  = src;
    w.dst  = dst;
    w.ksel = ksel;
    w.flow = flow;
    return w;
  endfunction

  // nine steps of one splitmix64 pass
  function automatic ctrl_t mix_word(logic [3:0] k, src_t s, dst_t d);
    ctrl_t w;
    case (k)
      4'd0:    w = cw(OP_LDPRE, s, d, K_A, FL_NEXT);
      4'd1:    w = cw(OP_ML0,   s, d, K_A, FL_NEXT);
      4'd2:    w = cw(OP_ML1,   s, d, K_A, FL_NEXT);
      4'd3:    w = cw(OP_ML2,   s, d, K_A, FL_NEXT);
      4'd4:    w = cw(OP_XS27,  s, d, K_A, FL_NEXT);
      4'd5:    w = cw(OP_ML0,   s, d, K_B, FL_NEXT);
      4'd6:    w = cw(OP_ML1,   s, d, K_B, FL_NEXT);
      4'd7:    w = cw(OP_ML2,   s, d, K_B, FL_NEXT);
      4'd8:    w = cw(OP_XS31,  s, d, K_B, FL_NEXT);
      default: w = cw(OP_NOP,   s, d, K_A, FL_NEXT);
    endcase
    return w;
  endfunction

  function automatic ctrl_t ucode(logic [PC_W-1:0] pc);
    ctrl_t w;
    logic [PC_W-1:0] k;
    k = '0;
    if (pc < 6'd9) begin
      w = mix_word(pc[3:0], SRC_LANE1, DST_LANE1);
    end else if (pc < 6'd18) begin
      k = pc - 6'd9;
      w = mix_word(k[3:0], SRC_LANE2, DST_LANE2);
    end else if (pc < 6'd27) begin
      k = pc - 6'd18;
      w = mix_word(k[3:0], SRC_POS, DST_CHAIN);
    end else if (pc == 6'd27) begin
      w = cw(OP_ML0, SRC_POS, DST_CHAIN, K_PRIME, FL_NEXT);
    end else if (pc == 6'd28) begin
      w = cw(OP_ML1, SRC_POS, DST_CHAIN, K_PRIME, FL_NEXT);
    end else if (pc == 6'd29) begin
      w = cw(OP_ML2, SRC_POS, DST_CHAIN, K_PRIME, FL_NEXT);
    end else if (pc == 6'd30) begin
      w = cw(OP_STEP, SRC_POS, DST_CHAIN, K_PRIME, FL_BYTE_END);
    end else if (pc < 6'd40) begin
      k = pc - CLOSE_ADDR;
      w = mix_word(k[3:0], SRC_FIN, DST_FIN);
    end else if (pc == 6'd40) begin
      w = cw(OP_EMIT, SRC_FIN, DST_FIN, K_A, FL_DONE);
    end else begin
      w = cw(OP_NOP, SRC_FIN, DST_FIN, K_A, FL_DONE);
    end
    return w;
  endfunction

endpackage

@@ rtl/byte_stream_dual_hash.sv @@
// top level: handshake, microcode sequencer and datapath of the byte stream dual hash
//
//   channel  | valid      | stall      | payload
//   ---------+------------+------------+------------------------------------------
//   input    | in_valid   | in_stall   | in_data_byte, in_byte_valid, in_last
//   result   | out_valid  | out_stall  | out_universal_hash, out_rolling_hash
//
// a beat with a byte runs 31 microcode steps, one per cycle; a closing beat adds 10 more
// three steps per 64-bit product on the single 32x32 multiplier set these counts
// a beat with neither byte nor close is taken and changes no hash state
// reset loads the seeds and leaves the sequencer idle with no result pending
// the result register holds a stalled beat while the next message streams in;
// a close waits at its emit step until the previous result is taken
module byte_stream_dual_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_universal_hash,
  output logic [63:0] out_rolling_hash
);
  import bsdh_pkg::*;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t          state_r;
  logic [PC_W-1:0] pc_r;
  logic            last_r;
  logic            out_valid_r;

  ctrl_t    word;
  dp_ctrl_t dp_ctrl;
  logic     accept, hold, exec;

  assign word     = ucode(pc_r);
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  // emit cannot overwrite a result that is still waiting
  assign hold     = (word.op == OP_EMIT) && out_valid_r;
  assign exec     = (state_r == ST_RUN) && !hold;

  always_comb begin
    dp_ctrl.exec      = exec;
    dp_ctrl.load_byte = accept;
    dp_ctrl.word      = word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= BYTE_ADDR;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            last_r <= in_last;
            if (in_byte_valid) begin
              pc_r    <= BYTE_ADDR;
              state_r <= ST_RUN;
            end else if (in_last) begin
              pc_r    <= CLOSE_ADDR;
              state_r <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (exec) begin
            case (word.flow)
              FL_NEXT: pc_r <= pc_r + 6'd1;
              FL_BYTE_END: begin
                if (last_r) begin
                  pc_r <= CLOSE_ADDR;
                end else begin
                  state_r <= ST_IDLE;
                end
              end
              FL_DONE: begin
                state_r     <= ST_IDLE;
                out_valid_r <= 1'b1;
              end
              default: state_r <= ST_IDLE;
            endcase
          end
        end
      endcase
    end
  end

  bsdh_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (dp_ctrl),
    .data_byte      (in_data_byte),
    .universal_hash (out_universal_hash),
    .rolling_hash   (out_rolling_hash)
  );

  assign out_valid = out_valid_r;

endmodule

@@ rtl/bsdh_datapath.sv @@
// hash state, shared 32x32 multiplier and result registers driven by the control word
module bsdh_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  bsdh_pkg::dp_ctrl_t ctrl,
  input  logic [7:0]         data_byte,
  output logic [63:0]        universal_hash,
  output logic [63:0]        rolling_hash
);
  import bsdh_pkg::*;

  logic [7:0]  b_r;
  logic [63:0] lane1_r, lane2_r, chain_r, count_r, wg_r;
  logic [63:0] x_r, acc_r;
  logic [63:0] uni_r, roll_r;

  logic [63:0] b_ext, src, pre_t, kval, prod, xs31, x_xs27;
  logic [39:0] b_lane;
  logic [31:0] mul_a, mul_b;
  ctrl_t       w;

  assign w     = ctrl.word;
  assign b_ext = {56'd0, b_r};
  assign b_lane = {32'd0, b_r} * {8'd0, LANE_MUL};

  always_comb begin
    case (w.src)
      SRC_LANE1: src = lane1_r ^ b_ext;
      SRC_LANE2: src = lane2_r + {24'd0, b_lane};
      SRC_POS:   src = b_ext + wg_r + GOLDEN;   // wg holds count * golden
      SRC_FIN:   src = chain_r ^ count_r;
      default:   src = chain_r ^ count_r;
    endcase
  end

  always_comb begin
    case (w.ksel)
      K_A:     kval = MIX_MUL_A;
      K_B:     kval = MIX_MUL_B;
      K_PRIME: kval = CHAIN_PRIME;
      default: kval = CHAIN_PRIME;
    endcase
  end

  assign pre_t  = src + GOLDEN;
  assign mul_a  = (w.op == OP_ML2) ? x_r[63:32] : x_r[31:0];
  assign mul_b  = (w.op == OP_ML1) ? kval[63:32] : kval[31:0];
  assign prod   = {32'd0, mul_a} * {32'd0, mul_b};
  assign xs31   = x_r ^ (x_r >> 31);
  assign x_xs27 = x_r ^ (x_r >> 27);

  always_ff @(posedge clk) begin
    if (ctrl.load_byte) begin
      b_r <= data_byte;
    end
    if (ctrl.exec) begin
      case (w.op)
        OP_LDPRE: x_r   <= pre_t ^ (pre_t >> 30);
        OP_ML0:   acc_r <= prod;
        OP_ML1:   acc_r <= acc_r + {prod[31:0], 32'd0};
        OP_ML2:   x_r   <= acc_r + {prod[31:0], 32'd0};
        OP_XS27:  x_r   <= x_xs27;
        OP_XS31: begin
          if (w.dst == DST_CHAIN) begin
            x_r <= chain_r ^ xs31;
          end else if (w.dst == DST_FIN) begin
            x_r <= xs31;
          end
        end
        OP_EMIT: begin
          uni_r  <= lane1_r ^ (lane2_r << 1);
          roll_r <= x_r;
        end
        default: ;
      endcase
    end
  end

  // hash state with seeded reset, reseeded after every close
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane1_r <= SEED_ONE;
      lane2_r <= SEED_TWO;
      chain_r <= CHAIN_INIT;
      count_r <= '0;
      wg_r    <= '0;
    end else if (ctrl.exec) begin
      case (w.op)
        OP_XS31: begin
          if (w.dst == DST_LANE1) begin
            lane1_r <= xs31;
          end else if (w.dst == DST_LANE2) begin
            lane2_r <= xs31;
          end
        end
        OP_STEP: begin
          chain_r <= x_r;
          count_r <= count_r + 64'd1;
          wg_r    <= wg_r + GOLDEN;
        end
        OP_EMIT: begin
          lane1_r <= SEED_ONE;
          lane2_r <= SEED_TWO;
          chain_r <= CHAIN_INIT;
          count_r <= '0;
          wg_r    <= '0;
        end
        default: ;
      endcase
    end
  end

  assign universal_hash = uni_r;
  assign rolling_hash   = roll_r;

endmodule

@@ sim/hash_digest_checker.sv @@
// checker for the byte stream dual hash: predicts both digests of each message and compares
module hash_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] out_universal_hash,
  input  logic [63:0] out_rolling_hash,
  output int          fail_count,
  output int          pending,
  output int          in_beats,
  output int          out_beats
);
  import bsdh_pkg::*;

  typedef struct packed {
    logic [63:0] universal;
    logic [63:0] rolling;
  } digest_t;

  logic [63:0] lane_a;
  logic [63:0] lane_b;
  logic [63:0] chain;
  logic [63:0] msg_len;
  digest_t     expected_digests[$];

  function automatic logic [63:0] splitmix(input logic [63:0] v);
    logic [63:0] t;
    t = v + GOLDEN;
    t = (t ^ (t >> 30)) * MIX_MUL_A;
    t = (t ^ (t >> 27)) * MIX_MUL_B;
    return t ^ (t >> 31);
  endfunction

  task automatic restart_message();
    lane_a  = SEED_ONE;
    lane_b  = SEED_TWO;
    chain   = CHAIN_INIT;
    msg_len = '0;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on %s at %0t: got %h expected %h", what, $time, got, want);
    fail_count++;
  endtask

  // a byte is folded in before a close carried by the same beat
  task automatic absorb(input logic [7:0] b, input logic take, input logic close);
    logic [63:0] pos;
    logic [63:0] wide_b;
    digest_t     d;
    wide_b = {56'd0, b};
    if (take) begin
      pos     = msg_len + 64'd1;
      lane_a  = splitmix(lane_a ^ wide_b);
      lane_b  = splitmix(lane_b + wide_b * {32'd0, LANE_MUL});
      chain   = (chain ^ splitmix(wide_b + pos * GOLDEN)) * CHAIN_PRIME;
      msg_len = pos;
    end
    if (close) begin
      d.universal = lane_a ^ (lane_b << 1);
      d.rolling   = splitmix(chain ^ msg_len);
      expected_digests.push_back(d);
      restart_message();
    end
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    in_beats   = 0;
    out_beats  = 0;
    restart_message();
  end

  always @(posedge clk) begin : watch
    digest_t want;
    if (!rst_n) begin
      restart_message();
      expected_digests.delete();
    end else begin
      if (in_valid && !in_stall) begin
        absorb(in_data_byte, in_byte_valid, in_last);
        in_beats++;
      end
      if (out_valid && !out_stall) begin
        out_beats++;
        if (expected_digests.size() == 0) begin
          report_mismatch("result beat with no closed message", out_universal_hash, '0);
        end else begin
          want = expected_digests.pop_front();
          if (out_universal_hash !== want.universal)
            report_mismatch("universal_hash", out_universal_hash, want.universal);
          if (out_rolling_hash !== want.rolling)
            report_mismatch("rolling_hash", out_rolling_hash, want.rolling);
        end
      end
    end
    pending = expected_digests.size();
  end

endmodule

@@ sim/testbench.sv @@
// top of the byte stream dual hash test: clock, reset, message stimulus, result pacing, verdict
module testbench;
  import bsdh_pkg::*;

  localparam int ITEM_TARGET = 1050;
  localparam int HOLD_AFTER  = 300;
  localparam int HOLD_CYCLES = 1500;
  localparam int IDLE_LIMIT  = 6000;
  localparam int TAIL_CYCLES = 60;

  typedef enum {PACE_FREE, PACE_LIGHT, PACE_HALF, PACE_HEAVY} recv_pace_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_byte_valid;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_universal_hash;
  logic [63:0] out_rolling_hash;

  int fail_count;
  int pending;
  int in_beats;
  int out_beats;
  int burst_left;
  bit hold_req;
  bit hold_done;

  byte_stream_dual_hash u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_byte_valid      (in_byte_valid),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_universal_hash (out_universal_hash),
    .out_rolling_hash   (out_rolling_hash)
  );

  hash_digest_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_byte_valid      (in_byte_valid),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_universal_hash (out_universal_hash),
    .out_rolling_hash   (out_rolling_hash),
    .fail_count         (fail_count),
    .pending            (pending),
    .in_beats           (in_beats),
    .out_beats          (out_beats)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_beat(input logic [7:0] b, input logic take, input logic close);
    int gap_cycles;
    int target;
    if (burst_left == 0) begin
      gap_cycles = $urandom_range(0, 12);
      if (gap_cycles != 0) begin
        in_valid <= 1'b0;
        repeat (gap_cycles) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_byte_valid <= take;
    in_last       <= close;
    target = in_beats + 1;
    do @(negedge clk); while (in_beats < target);
  endtask

  initial begin : receiver
    recv_pace_t pace;
    int         pace_left;
    pace      = PACE_FREE;
    pace_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        // long hold-off so the block fills up and stalls its input
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        if (pace_left == 0) begin
          pace      = recv_pace_t'($urandom_range(0, 3));
          pace_left = $urandom_range(50, 400);
        end
        pace_left--;
        case (pace)
          PACE_FREE:  out_stall <= 1'b0;
          PACE_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          PACE_HALF:  out_stall <= ($urandom_range(0, 1) == 1);
          default:    out_stall <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int idle;
    int last_in;
    int last_out;
    idle     = 0;
    last_in  = 0;
    last_out = 0;
    wait (rst_n === 1'b1);
    while (idle < IDLE_LIMIT) begin
      @(negedge clk);
      if (in_beats == last_in && out_beats == last_out) idle++;
      else idle = 0;
      last_in  = in_beats;
      last_out = out_beats;
    end
    $display("byte_stream_dual_hash test failed");
    $finish;
  end

  initial begin : stimulus
    int items;
    int body_len;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data_byte  = '0;
    in_byte_valid = 1'b0;
    in_last       = 1'b0;
    burst_left    = 0;
    hold_req      = 1'b0;
    hold_done     = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty messages, idle beats, single extreme bytes
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'h5a, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'hff, 1'b1, 1'b1);
    send_beat(8'h00, 1'b1, 1'b1);
    // walking one across the byte
    for (int i = 0; i < 8; i++)
      send_beat(8'h01 << i, 1'b1, i == 7);
    // idle inside a message, then a close carrying no byte
    send_beat(8'ha5, 1'b1, 1'b0);
    send_beat(8'h3c, 1'b0, 1'b0);
    send_beat(8'hc3, 1'b1, 1'b0);
    send_beat(8'hff, 1'b0, 1'b1);
    send_beat(8'hff, 1'b1, 1'b0);
    send_beat(8'hff, 1'b1, 1'b0);
    send_beat(8'hff, 1'b1, 1'b1);

    items = 0;
    while (items < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) body_len = $urandom_range(9, 40);
      else body_len = $urandom_range(0, 8);
      for (int k = 0; k < body_len; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
          items++;
        end
        send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        items++;
      end
      if ($urandom_range(0, 1)) send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      else send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      items++;
      if (items >= HOLD_AFTER) hold_req = 1'b1;
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) $display("byte_stream_dual_hash test passed");
    else $display("byte_stream_dual_hash test failed");
    $finish;
  end

endmodule

@@ byte_stream_dual_hash.f @@
rtl/bsdh_pkg.sv
rtl/bsdh_datapath.sv
rtl/byte_stream_dual_hash.sv
sim/hash_digest_checker.sv
sim/testbench.sv
